[design/assert_macros.svh]
// Assertion macros shared by the checker files of the sample history ring.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, sampled on the rising clock edge and off during reset.
`define SHTD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SHTD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SHTD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/shtd_pkg.sv]
// Package with the shared types and constants of the sample history ring.
`default_nettype none

package shtd_pkg;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 72;
   localparam int SAMPLE_W    = 4;
   localparam int BYTE_W      = 8;
   localparam int CHAR_W      = 7;
   localparam int NUM_CHARS   = 9;
   localparam int COUNT_W     = 4;

   // Command byte that starts a dump.
   localparam logic [BYTE_W-1:0] CMD_DUMP = 8'd68;

   // Kind codes carried on the request side.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_BYTE   = 1'b1;

   // ASCII characters used in the text groups.
   localparam logic [CHAR_W-1:0] CHR_HASH    = 7'd35;
   localparam logic [CHAR_W-1:0] CHR_E       = 7'd101;
   localparam logic [CHAR_W-1:0] CHR_L       = 7'd108;
   localparam logic [CHAR_W-1:0] CHR_M       = 7'd109;
   localparam logic [CHAR_W-1:0] CHR_COLON   = 7'd58;
   localparam logic [CHAR_W-1:0] CHR_ZERO    = 7'd48;
   localparam logic [CHAR_W-1:0] CHR_ONE     = 7'd49;
   localparam logic [CHAR_W-1:0] CHR_DASH    = 7'd45;
   localparam logic [CHAR_W-1:0] CHR_COMMA   = 7'd44;
   localparam logic [CHAR_W-1:0] CHR_NEWLINE = 7'd10;
   localparam logic [CHAR_W-1:0] CHR_NONE    = 7'd0;

   // Group lengths.
   localparam logic [COUNT_W-1:0] LEN_HEADER_SHORT = 4'd8;
   localparam logic [COUNT_W-1:0] LEN_HEADER_LONG  = 4'd9;
   localparam logic [COUNT_W-1:0] LEN_ENTRY        = 4'd5;
   localparam logic [COUNT_W-1:0] LEN_NEWLINE      = 4'd1;

   // Count from which the header carries a tens digit.
   localparam logic [4:0] TENS_LIMIT = 5'd10;

   typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] chars_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;         // advance the write pointer and store the sample
      logic start;         // latch the read pointer and entry count for a dump
      logic load_header;   // place the header group in the output register
      logic load_newline;  // place the lone newline group and clear the ring
      logic rd;            // read the entry at the read pointer
      logic load_entry;    // place one entry group, step the read pointer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sample_item;   // request beat carries a sample
      logic dump_item;     // request beat carries the dump command
      logic out_free;      // output register can take a group this cycle
      logic cnt_zero;      // dump has no entries
      logic last_entry;    // the entry being placed is the oldest one
   } sts_type;

endpackage

`default_nettype wire

[design/shtd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module shtd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/shtd_ctrl.sv]
// Controller state machine that sequences sample stores and text dumps.
`default_nettype none

module shtd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire shtd_pkg::sts_type sts,
   output shtd_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_NEWLINE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && sts.sample_item) begin
               cmd.store = 1'b1;
            end else if (accept && sts.dump_item) begin
               cmd.start = 1'b1;
               state_in  = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (sts.out_free) begin
               cmd.load_header = 1'b1;
               state_in        = sts.cnt_zero ? ST_NEWLINE : ST_READ;
            end
         end
         ST_NEWLINE: begin
            if (sts.out_free) begin
               cmd.load_newline = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_entry = 1'b1;
               state_in       = sts.last_entry ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/shtd_datapath.sv]
// Datapath: ring pointers, sample memory, text group formatting and output register.
`default_nettype none

module shtd_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire shtd_pkg::cmd_type                   cmd,
   output shtd_pkg::sts_type                        sts,
   input  wire logic [shtd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                                req_tuser,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic      [shtd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam int PAD_W = shtd_pkg::RSP_TDATA_W - shtd_pkg::COUNT_W
                          - shtd_pkg::NUM_CHARS * shtd_pkg::CHAR_W;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             valid_ff, valid_in;

   logic [shtd_pkg::COUNT_W-1:0] count_ff, count_in;
   shtd_pkg::chars_type          chars_ff, chars_in;
   logic                         last_ff, last_in;

   logic [shtd_pkg::SAMPLE_W-1:0] sample;
   logic [shtd_pkg::BYTE_W-1:0]   rx_byte;
   logic [shtd_pkg::SAMPLE_W-1:0] rd_data;
   logic [PTR_W-1:0]              wr_next;
   logic [4:0]                    cnt5;
   logic                          has_tens;
   logic [3:0]                    units;
   logic [shtd_pkg::CHAR_W-1:0]   units_chr;
   logic                          out_free;
   logic                          clear;

   assign sample  = req_tdata[shtd_pkg::SAMPLE_W-1:0];
   assign rx_byte = req_tdata[shtd_pkg::SAMPLE_W +: shtd_pkg::BYTE_W];

   assign out_free = !valid_ff || rsp_tready;

   assign sts.sample_item = (req_tuser == shtd_pkg::FUNC_SAMPLE);
   assign sts.dump_item   = (req_tuser == shtd_pkg::FUNC_BYTE)
                            && (rx_byte == shtd_pkg::CMD_DUMP);
   assign sts.out_free    = out_free;
   assign sts.cnt_zero    = (remain_ff == '0);
   assign sts.last_entry  = (remain_ff == CNT_W'(1));

   // The pointer moves first, so the store lands on the advanced slot.
   assign wr_next = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + PTR_W'(1);

   shtd_ram #(
      .WIDTH (shtd_pkg::SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (wr_next),
      .wr_data (sample),
      .rd_en   (cmd.rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Decimal count for the header; the count never exceeds sixteen.
   assign cnt5      = 5'(remain_ff);
   assign has_tens  = (cnt5 >= shtd_pkg::TENS_LIMIT);
   assign units     = has_tens ? 4'(cnt5 - shtd_pkg::TENS_LIMIT) : 4'(cnt5);
   assign units_chr = shtd_pkg::CHR_ZERO + {3'b000, units};

   assign clear = cmd.load_newline || (cmd.load_entry && sts.last_entry);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      remain_in = remain_ff;
      if (cmd.store) begin
         wr_ptr_in = wr_next;
         if (fill_ff != CNT_FULL) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
      if (cmd.start) begin
         rd_ptr_in = wr_ptr_ff;
         remain_in = fill_ff;
      end
      if (cmd.load_entry) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? PTR_MAX : rd_ptr_ff - PTR_W'(1);
         remain_in = remain_ff - CNT_W'(1);
      end
      if (clear) begin
         wr_ptr_in = '0;
         fill_in   = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      count_in = count_ff;
      chars_in = chars_ff;
      last_in  = last_ff;
      if (cmd.load_header) begin
         valid_in    = 1'b1;
         last_in     = 1'b0;
         chars_in    = '0;
         chars_in[0] = shtd_pkg::CHR_HASH;
         chars_in[1] = shtd_pkg::CHR_E;
         chars_in[2] = shtd_pkg::CHR_L;
         chars_in[3] = shtd_pkg::CHR_E;
         chars_in[4] = shtd_pkg::CHR_M;
         chars_in[5] = shtd_pkg::CHR_COLON;
         if (has_tens) begin
            chars_in[6] = shtd_pkg::CHR_ONE;
            chars_in[7] = units_chr;
            chars_in[8] = shtd_pkg::CHR_DASH;
            count_in    = shtd_pkg::LEN_HEADER_LONG;
         end else begin
            chars_in[6] = units_chr;
            chars_in[7] = shtd_pkg::CHR_DASH;
            count_in    = shtd_pkg::LEN_HEADER_SHORT;
         end
      end else if (cmd.load_newline) begin
         valid_in    = 1'b1;
         last_in     = 1'b1;
         chars_in    = '0;
         chars_in[0] = shtd_pkg::CHR_NEWLINE;
         count_in    = shtd_pkg::LEN_NEWLINE;
      end else if (cmd.load_entry) begin
         valid_in    = 1'b1;
         last_in     = sts.last_entry;
         chars_in    = '0;
         chars_in[0] = shtd_pkg::CHR_ZERO | {6'b000000, rd_data[3]};
         chars_in[1] = shtd_pkg::CHR_ZERO | {6'b000000, rd_data[2]};
         chars_in[2] = shtd_pkg::CHR_ZERO | {6'b000000, rd_data[1]};
         chars_in[3] = shtd_pkg::CHR_ZERO | {6'b000000, rd_data[0]};
         chars_in[4] = sts.last_entry ? shtd_pkg::CHR_NEWLINE : shtd_pkg::CHR_COMMA;
         count_in    = shtd_pkg::LEN_ENTRY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         rd_ptr_ff <= '0;
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         rd_ptr_ff <= rd_ptr_in;
         remain_ff <= remain_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      chars_ff <= chars_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, chars_ff, count_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

[design/sample_history_ring_with_text_dump.sv]
// Top level of the sample history ring with its text dump, controller plus datapath.
// A sample beat is taken while the controller is idle and gives no response.
// A dump gives a header group, then one group per stored entry, newest first, or a lone
// newline group when the ring is empty; a registered read of the sample memory comes
// ahead of each entry group.
// Synchronous active-high reset empties the ring and the output register.
`default_nettype none

module sample_history_ring_with_text_dump #(
   // Number of ring slots, from 2 to 16.
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   // Request stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [3:0] sample, [11:4] rx_byte, [15:12] zero
   input  wire logic [shtd_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] func: 0 is a sample beat, 1 is a received command byte
   input  wire logic                             req_tuser,

   // Response stream of text groups.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [3:0] char_count, [10:4] char_0, [17:11] char_1, [24:18] char_2,
   // [31:25] char_3, [38:32] char_4, [45:39] char_5, [52:46] char_6,
   // [59:53] char_7, [66:60] char_8, [71:67] zero
   output logic      [shtd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Marks the final group of a dump.
   output logic                                  rsp_tlast
);

   // The controller only decides what happens each cycle; all storage that the
   // ring keeps (pointers, fill count, sample memory, output register) sits in
   // the datapath. The two talk through one command and one status bundle.
   shtd_pkg::cmd_type cmd;
   shtd_pkg::sts_type sts;

   // Requests are taken only between dumps. A finished group may still wait in
   // the output register while new samples are accepted; the next dump holds
   // its header until that register frees up.
   shtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath advances the write pointer before each store, so the first
   // sample after a clear lands in slot one. A dump walks backward from the
   // write pointer and clears the pointer and fill count with its last group.
   shtd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[design/shtd_checker.sv]
// Port-level checker for the sample history ring, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module shtd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [shtd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tlast
);

   logic [shtd_pkg::COUNT_W-1:0] count;
   logic [shtd_pkg::CHAR_W-1:0]  chr0;
   logic [shtd_pkg::CHAR_W-1:0]  chr4;

   assign count = rsp_tdata[shtd_pkg::COUNT_W-1:0];
   assign chr0  = rsp_tdata[shtd_pkg::COUNT_W +: shtd_pkg::CHAR_W];
   assign chr4  = rsp_tdata[shtd_pkg::COUNT_W + 4 * shtd_pkg::CHAR_W +: shtd_pkg::CHAR_W];

   // A stalled beat keeps its content.
   `SHTD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response beat changed while stalled")

   // Every group carries between one and nine characters.
   `SHTD_ASSERT_IMP(a_count_range, clock, reset, rsp_tvalid,
      count != '0 && count <= shtd_pkg::LEN_HEADER_LONG, "group character count out of range")

   // The final group ends in a newline, either alone or after four digits.
   `SHTD_ASSERT_IMP(a_last_newline, clock, reset, rsp_tvalid && rsp_tlast,
      (count == shtd_pkg::LEN_NEWLINE && chr0 == shtd_pkg::CHR_NEWLINE) ||
      (count == shtd_pkg::LEN_ENTRY && chr4 == shtd_pkg::CHR_NEWLINE),
      "final group does not end in a newline")

   // A header is never the final group of a dump.
   `SHTD_ASSERT_IMP(a_header_not_last, clock, reset, rsp_tvalid && chr0 == shtd_pkg::CHR_HASH,
      !rsp_tlast, "header group marked as final")

   // No request is taken while a dump's header group is pending and stalled.
   `SHTD_ASSERT_IMP(a_no_req_mid_dump, clock, reset,
      rsp_tvalid && !rsp_tlast && chr0 == shtd_pkg::CHR_HASH && !rsp_tready,
      !(req_tvalid && req_tready), "request accepted in the middle of a dump")

endmodule

bind sample_history_ring_with_text_dump shtd_checker u_shtd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for the sample history ring: a directed table, then random sample runs and dumps.
module tb;

   localparam int RING_DEPTH   = 16;
   // Watchdog limit, with a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT  = 200000;
   // Idle time at the end, longer than a full dump takes.
   localparam int DRAIN_CYCLES = 40;
   // Random samples and dumps to send after the table.
   localparam int RANDOM_BEATS = 245;
   // The last stretch of the run has no idling on either side.
   localparam int CALM_BEATS   = 40;

   // One text group as it travels on the response stream.
   typedef struct packed {
      logic [shtd_pkg::COUNT_W-1:0] count;
      shtd_pkg::chars_type          chars;
      logic                         last;
   } text_group_type;

   // One row of the directed table. The expected text sits in a queue beside it.
   typedef struct packed {
      logic                          func;
      logic [shtd_pkg::SAMPLE_W-1:0] sample;
      logic [shtd_pkg::BYTE_W-1:0]   rx;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [shtd_pkg::REQ_TDATA_W-1:0] req_tdata;   // [3:0] sample, [11:4] rx_byte, [15:12] zero
   logic                             req_tuser;   // [0] func
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [shtd_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // [3:0] char_count, then char_0..char_8
   logic                             rsp_tlast;

   // Our own copy of the ring, kept in step with every accepted request beat.
   logic [shtd_pkg::SAMPLE_W-1:0] ring_slots [RING_DEPTH];
   logic [3:0]                    ring_head;
   logic [4:0]                    ring_fill;

   // Text groups that the ring still owes us, oldest first.
   text_group_type pending_groups [$];

   stim_row_type table_rows [$];
   string        table_text [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  stall_left;
   bit  idle_on        = 1'b1;

   sample_history_ring_with_text_dump #(.DEPTH(RING_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Turns a piece of text into a group. Characters past the end stay zero.
   function automatic text_group_type text_to_group(input string s, input logic fin);
      text_group_type g;
      int             n;
      byte            c;
      g = '0;
      n = s.len();
      g.count = n[shtd_pkg::COUNT_W-1:0];
      for (int k = 0; k < s.len(); k++) begin
         c = s[k];
         g.chars[k] = c[shtd_pkg::CHAR_W-1:0];
      end
      g.last = fin;
      return g;
   endfunction

   // Hand-written expectations: groups separated by spaces, the final one marked last.
   task automatic queue_typed_text(input string txt);
      string piece;
      piece = "";
      for (int k = 0; k < txt.len(); k++) begin
         if (txt[k] == " ") begin
            pending_groups.push_back(text_to_group(piece, 1'b0));
            piece = "";
         end else begin
            piece = {piece, string'(txt[k])};
         end
      end
      pending_groups.push_back(text_to_group(piece, 1'b1));
   endtask

   // Applies one accepted request beat to our ring copy and, when keep is set, queues
   // the text groups that the dump should produce.
   task automatic predict_text_groups(input logic fn,
                                      input logic [shtd_pkg::SAMPLE_W-1:0] smp,
                                      input logic [shtd_pkg::BYTE_W-1:0] rx, input bit keep);
      logic [3:0] slot;
      logic [4:0] n_ent;
      if (fn == shtd_pkg::FUNC_SAMPLE) begin
         // The pointer moves first, so a fresh ring fills from slot 1.
         ring_head = (ring_head == RING_DEPTH - 1) ? 4'd0 : ring_head + 4'd1;
         ring_slots[ring_head] = smp;
         if (ring_fill < RING_DEPTH) ring_fill = ring_fill + 5'd1;
      end else if (rx == shtd_pkg::CMD_DUMP) begin
         n_ent = ring_fill;
         if (keep) begin
            pending_groups.push_back(text_to_group($sformatf("#elem:%0d-", n_ent), 1'b0));
            if (n_ent == 0) begin
               // An empty ring still ends its dump with a lone newline.
               pending_groups.push_back(text_to_group("\n", 1'b1));
            end
            // Newest entry first, walking the pointer backward around the ring.
            for (int i = 0; i < n_ent; i++) begin
               slot = 4'((ring_head + RING_DEPTH - i) % RING_DEPTH);
               pending_groups.push_back(text_to_group(
                  $sformatf("%04b%s", ring_slots[slot], (i + 1 == n_ent) ? "\n" : ","),
                  i + 1 == n_ent));
            end
         end
         ring_fill = 5'd0;
         ring_head = 4'd0;
      end
   endtask

   task automatic put_row(input logic fn, input logic [shtd_pkg::SAMPLE_W-1:0] smp,
                          input logic [shtd_pkg::BYTE_W-1:0] rx, input string txt);
      stim_row_type r;
      r.func   = fn;
      r.sample = smp;
      r.rx     = rx;
      table_rows.push_back(r);
      table_text.push_back(txt);
   endtask

   // Drives one request beat and holds it until the ring takes it. Valid stays high
   // between back-to-back beats and only drops for an idle burst.
   task automatic send_beat(input logic fn, input logic [shtd_pkg::SAMPLE_W-1:0] smp,
                            input logic [shtd_pkg::BYTE_W-1:0] rx, input string typed);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {4'b0000, rx, smp};
      do @(posedge clock); while (!req_tready);
      if (typed.len() == 0) begin
         predict_text_groups(fn, smp, rx, 1'b1);
      end else begin
         predict_text_groups(fn, smp, rx, 1'b0);
         queue_typed_text(typed);
      end
   endtask

   // Holds the request side off until every owed text group has come back.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_groups.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
   endtask

   // Compares one accepted text group with the oldest one owed.
   task automatic check_group();
      text_group_type want;
      text_group_type got;
      got.count = rsp_tdata[3:0];
      got.chars = rsp_tdata[4 +: shtd_pkg::NUM_CHARS * shtd_pkg::CHAR_W];
      got.last  = rsp_tlast;
      if (pending_groups.size() == 0) begin
         mismatch_count++;
         $display("%0t: text group expected none actual count %0d last %0b",
                  $time, got.count, got.last);
      end else begin
         want = pending_groups.pop_front();
         if (got.count != want.count) begin
            report_field("char_count", int'(want.count), int'(got.count));
         end
         for (int k = 0; k < shtd_pkg::NUM_CHARS; k++) begin
            if (got.chars[k] != want.chars[k]) begin
               report_field($sformatf("char_%0d", k), int'(want.chars[k]),
                            int'(got.chars[k]));
            end
         end
         if (got.last != want.last) report_field("last", int'(want.last), int'(got.last));
      end
   endtask

   // Response side: takes groups and stalls in short random bursts while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_group();
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= int'($urandom_range(0, 2));
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sample_history_ring_with_text_dump: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int                          issued;
      int                          run_len;
      int                          next_quiet;
      logic [shtd_pkg::BYTE_W-1:0] rx;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= shtd_pkg::FUNC_SAMPLE;
      req_tdata  <= '0;
      ring_head  = 4'd0;
      ring_fill  = 5'd0;
      for (int i = 0; i < RING_DEPTH; i++) ring_slots[i] = '0;

      // Directed table. Rows with text carry their expected groups typed in;
      // rows with empty text go through the predictor.
      // A dump straight out of reset finds an empty ring.
      put_row(shtd_pkg::FUNC_BYTE,   4'h0, shtd_pkg::CMD_DUMP, "#elem:0- \n");
      // Both sample extremes, read back newest first.
      put_row(shtd_pkg::FUNC_SAMPLE, 4'hF, 8'h00,              "");
      put_row(shtd_pkg::FUNC_SAMPLE, 4'h0, 8'hFF,              "");
      put_row(shtd_pkg::FUNC_BYTE,   4'hF, shtd_pkg::CMD_DUMP, "#elem:2- 0000, 1111\n");
      // Bytes other than the dump command are ignored and give nothing back.
      put_row(shtd_pkg::FUNC_BYTE,   4'hF, 8'hFF,              "");
      put_row(shtd_pkg::FUNC_BYTE,   4'h0, 8'h00,              "");
      put_row(shtd_pkg::FUNC_BYTE,   4'h5, 8'h64,              "");
      // The previous dump cleared the ring, so this one is empty again.
      put_row(shtd_pkg::FUNC_BYTE,   4'h0, shtd_pkg::CMD_DUMP, "#elem:0- \n");
      // Seventeen samples wrap the pointer and saturate the count at sixteen; the
      // dump command byte on a sample beat must not start a dump.
      for (int i = 0; i < 17; i++) begin
         put_row(shtd_pkg::FUNC_SAMPLE, i[3:0], shtd_pkg::CMD_DUMP, "");
      end
      put_row(shtd_pkg::FUNC_BYTE,   4'h0, shtd_pkg::CMD_DUMP, "");

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         send_beat(table_rows[i].func, table_rows[i].sample, table_rows[i].rx,
                   table_text[i]);
      end
      wait_for_quiet();

      // Random part: mostly sample runs closed by a dump, with stray bytes mixed in.
      // Short runs dominate, but long runs keep hitting the wrap and the two-digit
      // header.
      issued     = 0;
      next_quiet = 60;
      while (issued < RANDOM_BEATS) begin
         idle_on = (issued < RANDOM_BEATS - CALM_BEATS) && ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 9) < 8) begin
            run_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(10, 20))
                                                  : int'($urandom_range(0, 9));
            repeat (run_len) begin
               send_beat(shtd_pkg::FUNC_SAMPLE, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), "");
               issued++;
            end
            if ($urandom_range(0, 3) == 0) begin
               rx = 8'($urandom_range(0, 255));
               if (rx == shtd_pkg::CMD_DUMP) rx = rx ^ 8'h01;
               send_beat(shtd_pkg::FUNC_BYTE, 4'($urandom_range(0, 15)), rx, "");
            end
            send_beat(shtd_pkg::FUNC_BYTE, 4'($urandom_range(0, 15)), shtd_pkg::CMD_DUMP, "");
            issued++;
         end else begin
            // Loose command byte; now and then it happens to be a dump.
            rx = 8'($urandom_range(0, 255));
            send_beat(shtd_pkg::FUNC_BYTE, 4'($urandom_range(0, 15)), rx, "");
            if (rx == shtd_pkg::CMD_DUMP) issued++;
         end
         if (issued >= next_quiet) begin
            wait_for_quiet();
            next_quiet += 60;
         end
      end

      idle_on = 1'b0;
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sample_history_ring_with_text_dump: match");
      end else begin
         $display("sample_history_ring_with_text_dump: mismatch");
      end
      $finish;
   end

endmodule
